// ===== hw/rtl/c3z_pkg.sv =====
`timescale 1ns / 1ps

package c3z_pkg;

  // field widths
  localparam int PIX_W    = 16;
  localparam int COEF_W   = 16;
  localparam int ROWC_W   = 3 * COEF_W;
  localparam int VAL_W    = 27;
  localparam int ROW_W    = 12;
  localparam int COL_W    = 10;
  localparam int WID_W    = 11;
  localparam int HGT_W    = 13;
  localparam int PROD_W   = PIX_W + COEF_W;
  localparam int SUM_W    = PROD_W + 4;
  localparam int FRAC_W   = 8;
  localparam int TAPS     = 9;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ROWC_W;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 56;

  localparam int COL_LIMIT       = 1024;
  localparam int ROW_LIMIT       = 4096;
  localparam int DEF_MAX_WIDTH   = 1024;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_MID     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_BOT     = 3'd4;

  // reset values: vertical sobel kernel in q8.8
  localparam logic [WID_W-1:0]  RST_FRAME_WIDTH  = 11'd10;
  localparam logic [HGT_W-1:0]  RST_FRAME_HEIGHT = 13'd10;
  localparam logic [ROWC_W-1:0] RST_COEF_TOP     = 48'h0100_0200_0100;
  localparam logic [ROWC_W-1:0] RST_COEF_MID     = 48'h0000_0000_0000;
  localparam logic [ROWC_W-1:0] RST_COEF_BOT     = 48'hFF00_FE00_FF00;

  typedef logic [2:0][ROWC_W-1:0] coeff_rows_t;

  typedef struct packed {
    logic [WID_W-1:0] width;
    logic [HGT_W-1:0] height;
  } geom_t;

  typedef struct packed {
    logic             en;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
  } lbuf_wr_t;

  typedef struct packed {
    logic [TAPS-1:0][PIX_W-1:0] pix;
    logic [TAPS-1:0]            keep;
    logic [ROW_W-1:0]           row;
    logic [COL_W-1:0]           col;
    logic                       run_last;
    logic                       frame_end;
  } job_t;

endpackage

// ===== hw/rtl/conv3x3_zero_border.sv =====
`timescale 1ns / 1ps
// 3x3 signed q8.8 correlation over a raster pixel stream, zero outside the frame
// each result passes stage 1, the window stage, the product and output registers
// throughput: one pixel per cycle while out_tready is high; an input with n > 1 results
//   (last column or row only) holds in_tready low while the mac takes one per cycle
// reset: rst_n synchronous active low; geometry 10x10, sobel coefficients, position (0,0)
//   line store contents are not cleared, rows outside the frame are never used

module conv3x3_zero_border
  import c3z_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input pixel stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] pixel
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [26:0] value, [38:27] out_row,
                                             // [48:39] out_col, [55:49] zero
  output logic                   out_tlast,  // run_last
  output logic                   out_tuser,  // [0] frame_end
  // register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // line store depth: widths above the column field can never be used
  localparam int LINE_DEPTH = (MAX_WIDTH < COL_LIMIT) ? MAX_WIDTH : COL_LIMIT;
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam logic [WID_W-1:0] W_LIM = WID_W'(LINE_DEPTH);
  localparam logic [HGT_W-1:0] H_LIM = HGT_W'(ROW_LIMIT);

  // configuration registers
  logic [WID_W-1:0] frame_width_r;
  logic [HGT_W-1:0] frame_height_r;
  coeff_rows_t      coeff_r;

  // raster position of the next pixel
  logic [ROW_W-1:0] row_cnt_r;
  logic [COL_W-1:0] col_cnt_r;

  geom_t            geom;
  logic             in_fire;
  logic             restart;
  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] cur_col;
  logic [WID_W-1:0] col_inc;
  logic [HGT_W-1:0] row_inc;

  logic [PIX_W-1:0]  rd_top, rd_mid;
  lbuf_wr_t          lb_wr;
  logic [ADDR_W-1:0] lb_wr_addr;

  logic             job_valid, job_ready;
  job_t             job;

  logic             res_valid;
  logic [VAL_W-1:0] res_value;
  logic [ROW_W-1:0] res_row;
  logic [COL_W-1:0] res_col;
  logic             res_last, res_fend;

  // registers are always writable; writes outside the register list are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      coeff_r[0]     <= RST_COEF_TOP;
      coeff_r[1]     <= RST_COEF_MID;
      coeff_r[2]     <= RST_COEF_BOT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[WID_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[HGT_W-1:0];
        CFG_COEF_TOP:     coeff_r[0]     <= cfg_data;
        CFG_COEF_MID:     coeff_r[1]     <= cfg_data;
        CFG_COEF_BOT:     coeff_r[2]     <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective geometry: zero acts as one, oversize is clipped
  always_comb begin
    if (frame_width_r == '0) begin
      geom.width = WID_W'(1);
    end else if (frame_width_r > W_LIM) begin
      geom.width = W_LIM;
    end else begin
      geom.width = frame_width_r;
    end
    if (frame_height_r == '0) begin
      geom.height = HGT_W'(1);
    end else if (frame_height_r > H_LIM) begin
      geom.height = H_LIM;
    end else begin
      geom.height = frame_height_r;
    end
  end

  // a position outside a shrunk frame restarts at the origin
  assign restart = ({1'b0, col_cnt_r} >= geom.width) || ({1'b0, row_cnt_r} >= geom.height);
  assign cur_row = restart ? '0 : row_cnt_r;
  assign cur_col = restart ? '0 : col_cnt_r;
  assign col_inc = {1'b0, cur_col} + WID_W'(1);
  assign row_inc = {1'b0, cur_row} + HGT_W'(1);

  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else if (in_fire) begin
      if (col_inc >= geom.width) begin
        col_cnt_r <= '0;
        row_cnt_r <= (row_inc >= geom.height) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_cnt_r <= col_inc[COL_W-1:0];
        row_cnt_r <= cur_row;
      end
    end
  end

  // line store read is issued on the input transfer, data lands with stage 1
  c3z_line_buf #(
    .DEPTH  (LINE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (cur_col[ADDR_W-1:0]),
    .rd_top  (rd_top),
    .rd_mid  (rd_mid),
    .wr      (lb_wr),
    .wr_addr (lb_wr_addr)
  );

  // window shift, line store write-back and per-result tap selection
  c3z_win #(
    .ADDR_W (ADDR_W)
  ) u_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .ld_valid  (in_fire),
    .ld_ready  (in_tready),
    .ld_px     (in_tdata[PIX_W-1:0]),
    .ld_row    (cur_row),
    .ld_col    (cur_col),
    .rd_top    (rd_top),
    .rd_mid    (rd_mid),
    .wr        (lb_wr),
    .wr_addr   (lb_wr_addr),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  // nine multipliers, registered, then the sum and shift into the output register
  c3z_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .coeffs    (coeff_r),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .res_valid (res_valid),
    .res_ready (out_tready),
    .res_value (res_value),
    .res_row   (res_row),
    .res_col   (res_col),
    .res_last  (res_last),
    .res_fend  (res_fend)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {(OUT_TDATA_W - VAL_W - ROW_W - COL_W)'(0), res_col, res_row, res_value};
  assign out_tlast  = res_last;
  assign out_tuser  = res_fend;

endmodule

// ===== hw/rtl/c3z_line_buf.sv =====
`timescale 1ns / 1ps

module c3z_line_buf
  import c3z_pkg::*;
#(
  parameter int DEPTH  = DEF_MAX_WIDTH,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [PIX_W-1:0]  rd_top,
  output logic [PIX_W-1:0]  rd_mid,
  input  lbuf_wr_t          wr,
  input  logic [ADDR_W-1:0] wr_addr
);

  // two rows back and one row back
  logic [PIX_W-1:0] top_mem [DEPTH];
  logic [PIX_W-1:0] mid_mem [DEPTH];
  logic [PIX_W-1:0] rd_top_r;
  logic [PIX_W-1:0] rd_mid_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      top_mem[wr_addr] <= wr.top;
      mid_mem[wr_addr] <= wr.mid;
    end
    if (rd_en) begin
      rd_top_r <= top_mem[rd_addr];
      rd_mid_r <= mid_mem[rd_addr];
    end
  end

  assign rd_top = rd_top_r;
  assign rd_mid = rd_mid_r;

endmodule

// ===== hw/rtl/c3z_win.sv =====
`timescale 1ns / 1ps

module c3z_win
  import c3z_pkg::*;
#(
  parameter int ADDR_W = $clog2(DEF_MAX_WIDTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  geom_t             geom,
  input  logic              ld_valid,
  output logic              ld_ready,
  input  logic [PIX_W-1:0]  ld_px,
  input  logic [ROW_W-1:0]  ld_row,
  input  logic [COL_W-1:0]  ld_col,
  input  logic [PIX_W-1:0]  rd_top,
  input  logic [PIX_W-1:0]  rd_mid,
  output lbuf_wr_t          wr,
  output logic [ADDR_W-1:0] wr_addr,
  output logic              job_valid,
  input  logic              job_ready,
  output job_t              job
);

  // stage 1: pixel plus line store read data
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_px_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [COL_W-1:0] s1_col_r;
  logic             byp_r;
  logic [PIX_W-1:0] byp_top_r;
  logic [PIX_W-1:0] byp_mid_r;

  // stage 2: window and result sequencing
  logic [2:0][2:0][PIX_W-1:0] win_r;
  logic             s2_valid_r;
  logic [ROW_W-1:0] s2_row_r;
  logic [COL_W-1:0] s2_col_r;
  logic             up_r, rowcur_r, left_r, colcur_r;
  logic             a_r, b_r;

  logic             s1_fire, s2_ready, job_fire;
  logic [PIX_W-1:0] top_v, mid_v;
  logic [HGT_W-1:0] h_last;
  logic [WID_W-1:0] w_last;
  logic             ld_up, ld_rowcur, ld_left, ld_colcur;
  logic             dr, dc, last_a, last_b;
  logic [2:0]       row_ok, col_ok;
  logic [ROW_W-1:0] job_row;
  logic [COL_W-1:0] job_col;

  assign h_last = geom.height - HGT_W'(1);
  assign w_last = geom.width - WID_W'(1);

  assign job_fire = s2_valid_r && job_ready;
  assign s2_ready = !s2_valid_r || (job_fire && job.run_last);
  assign s1_fire  = s1_valid_r && s2_ready;
  assign ld_ready = !s1_valid_r || s1_fire;

  // same-cycle write to the address just read goes around the memory
  assign top_v = byp_r ? byp_top_r : rd_top;
  assign mid_v = byp_r ? byp_mid_r : rd_mid;

  assign wr      = '{en: s1_fire, top: mid_v, mid: s1_px_r};
  assign wr_addr = s1_col_r[ADDR_W-1:0];

  assign ld_up     = s1_row_r != '0;
  assign ld_rowcur = {1'b0, s1_row_r} == h_last;
  assign ld_left   = s1_col_r != '0;
  assign ld_colcur = {1'b0, s1_col_r} == w_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (ld_valid) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
    if (ld_valid) begin
      s1_px_r   <= ld_px;
      s1_row_r  <= ld_row;
      s1_col_r  <= ld_col;
      byp_r     <= s1_fire && (s1_col_r == ld_col);
      byp_top_r <= mid_v;
      byp_mid_r <= s1_px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      a_r        <= 1'b0;
      b_r        <= 1'b0;
    end else if (s1_fire) begin
      s2_valid_r <= (ld_up || ld_rowcur) && (ld_left || ld_colcur);
      a_r        <= 1'b0;
      b_r        <= 1'b0;
    end else if (job_fire) begin
      if (job.run_last) begin
        s2_valid_r <= 1'b0;
      end else if (last_b) begin
        a_r <= 1'b1;
        b_r <= 1'b0;
      end else begin
        b_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= top_v;
      win_r[1][2] <= mid_v;
      win_r[2][2] <= s1_px_r;
      s2_row_r    <= s1_row_r;
      s2_col_r    <= s1_col_r;
      up_r        <= ld_up;
      rowcur_r    <= ld_rowcur;
      left_r      <= ld_left;
      colcur_r    <= ld_colcur;
    end
  end

  // result order: row above before current row, column left before current
  assign dr     = a_r || !up_r;
  assign dc     = b_r || !left_r;
  assign last_a = a_r || !(up_r && rowcur_r);
  assign last_b = b_r || !(left_r && colcur_r);

  assign job_valid = s2_valid_r;
  assign job_row   = s2_row_r - ROW_W'(!dr);
  assign job_col   = s2_col_r - COL_W'(!dc);

  assign row_ok = {({1'b0, job_row} != h_last), 1'b1, (job_row != '0)};
  assign col_ok = {({1'b0, job_col} != w_last), 1'b1, (job_col != '0)};

  always_comb begin
    logic [1:0] wy;
    logic [1:0] wx;
    job.row       = job_row;
    job.col       = job_col;
    job.run_last  = last_a && last_b;
    job.frame_end = ({1'b0, job_row} == h_last) && ({1'b0, job_col} == w_last);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        wy = (dr && i != 2) ? 2'(i + 1) : 2'(i);
        wx = (dc && j != 2) ? 2'(j + 1) : 2'(j);
        job.pix[i*3+j]  = win_r[wy][wx];
        job.keep[i*3+j] = row_ok[i] && col_ok[j];
      end
    end
  end

endmodule

// ===== hw/rtl/c3z_mac.sv =====
`timescale 1ns / 1ps

module c3z_mac
  import c3z_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  coeff_rows_t      coeffs,
  input  logic             job_valid,
  output logic             job_ready,
  input  job_t             job,
  output logic             res_valid,
  input  logic             res_ready,
  output logic [VAL_W-1:0] res_value,
  output logic [ROW_W-1:0] res_row,
  output logic [COL_W-1:0] res_col,
  output logic             res_last,
  output logic             res_fend
);

  logic signed [PROD_W-1:0] prod_r [TAPS];
  logic                     s3_valid_r;
  logic [ROW_W-1:0]         s3_row_r;
  logic [COL_W-1:0]         s3_col_r;
  logic                     s3_last_r, s3_fend_r;

  logic                     out_valid_r;
  logic [VAL_W-1:0]         val_r;
  logic [ROW_W-1:0]         row_r;
  logic [COL_W-1:0]         col_r;
  logic                     last_r, fend_r;

  logic                     s4_load, job_fire;
  logic signed [COEF_W-1:0] coef [TAPS];
  logic signed [SUM_W-1:0]  sum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        coef[i*3+j] = $signed(coeffs[i][COEF_W*j +: COEF_W]);
      end
    end
  end

  assign s4_load   = s3_valid_r && (!out_valid_r || res_ready);
  assign job_ready = !s3_valid_r || s4_load;
  assign job_fire  = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (job_fire) begin
      s3_valid_r <= 1'b1;
    end else if (s4_load) begin
      s3_valid_r <= 1'b0;
    end
    if (job_fire) begin
      for (int k = 0; k < TAPS; k++) begin
        prod_r[k] <= job.keep[k] ? $signed(job.pix[k]) * coef[k] : PROD_W'(0);
      end
      s3_row_r  <= job.row;
      s3_col_r  <= job.col;
      s3_last_r <= job.run_last;
      s3_fend_r <= job.frame_end;
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < TAPS; k++) begin
      sum = sum + SUM_W'(prod_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s4_load) begin
      out_valid_r <= 1'b1;
    end else if (res_ready) begin
      out_valid_r <= 1'b0;
    end
    if (s4_load) begin
      // arithmetic shift by the fraction width rounds toward minus infinity
      val_r  <= sum[FRAC_W +: VAL_W];
      row_r  <= s3_row_r;
      col_r  <= s3_col_r;
      last_r <= s3_last_r;
      fend_r <= s3_fend_r;
    end
  end

  assign res_valid = out_valid_r;
  assign res_value = val_r;
  assign res_row   = row_r;
  assign res_col   = col_r;
  assign res_last  = last_r;
  assign res_fend  = fend_r;

endmodule

// ===== hw/rtl/c3z_checker.sv =====
`timescale 1ns / 1ps

module c3z_checker
  import c3z_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast,
  input logic                   out_tuser,
  input logic                   cfg_valid,
  input logic                   cfg_ready
);

  // no result survives a reset cycle
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // the final position of a frame is always the last result of its input
  a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("frame end without run end");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast)
                                  && $stable(out_tuser))
    else $error("stalled result changed");

  // register writes never stall
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("register write stalled");

endmodule

bind conv3x3_zero_border c3z_checker u_c3z_checker (.*);

// ===== tb/conv3x3_tb_pkg.sv =====
`timescale 1ns / 1ps

package conv3x3_tb_pkg;
  import c3z_pkg::*;

  // widest frame the block honors
  localparam int WIDTH_CAP = (DEF_MAX_WIDTH < COL_LIMIT) ? DEF_MAX_WIDTH : COL_LIMIT;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic                    run_last;
    logic                    frame_end;
  } conv_result_t;

  class conv_checker;
    logic [WID_W-1:0]  width_reg;
    logic [HGT_W-1:0]  height_reg;
    logic [ROWC_W-1:0] coef_rows [3];
    logic [PIX_W-1:0]  line_mem [2*DEF_MAX_WIDTH];
    logic [PIX_W-1:0]  win [3][3];
    int                row_pos;
    int                col_pos;
    int                errors;
    conv_result_t      expected_sums [$];

    function new();
      width_reg    = RST_FRAME_WIDTH;
      height_reg   = RST_FRAME_HEIGHT;
      coef_rows[0] = RST_COEF_TOP;
      coef_rows[1] = RST_COEF_MID;
      coef_rows[2] = RST_COEF_BOT;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      row_pos = 0;
      col_pos = 0;
      errors  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_FRAME_WIDTH:  width_reg = val[WID_W-1:0];
        CFG_FRAME_HEIGHT: height_reg = val[HGT_W-1:0];
        CFG_COEF_TOP:     coef_rows[0] = val;
        CFG_COEF_MID:     coef_rows[1] = val;
        CFG_COEF_BOT:     coef_rows[2] = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction

    // q8.8 sum around (rr,cc) from the window, newest input at (r,c)
    function longint window_sum(int rr, int cc, int r, int c, int w, int h);
      longint acc;
      int y, x, wy, wx;
      logic signed [COEF_W-1:0] kc;
      logic signed [PIX_W-1:0] pv;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        y  = rr + i - 1;
        wy = y - (r - 2);
        if (y >= 0 && y < h && wy >= 0 && wy <= 2) begin
          for (int j = 0; j < 3; j++) begin
            x  = cc + j - 1;
            wx = x - (c - 2);
            if (x >= 0 && x < w && wx >= 0 && wx <= 2) begin
              kc  = coef_rows[i][COEF_W*j +: COEF_W];
              pv  = win[wy][wx];
              acc = acc + longint'(kc) * longint'(pv);
            end
          end
        end
      end
      return acc >>> FRAC_W;
    endfunction

    function void take_pixel(logic [PIX_W-1:0] px);
      int w, h, r, c, nr, nc;
      int rows [2];
      int cols [2];
      logic [PIX_W-1:0] top, mid;
      conv_result_t res;
      w = (width_reg == 0) ? 1 : ((width_reg > WIDTH_CAP) ? WIDTH_CAP : int'(width_reg));
      h = (height_reg == 0) ? 1 : ((height_reg > ROW_LIMIT) ? ROW_LIMIT : int'(height_reg));
      // position outside a shrunken frame starts a new one
      if (col_pos >= w || row_pos >= h) begin
        row_pos = 0;
        col_pos = 0;
      end
      r   = row_pos;
      c   = col_pos;
      top = line_mem[DEF_MAX_WIDTH + c];
      mid = line_mem[c];
      for (int k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = px;
      line_mem[DEF_MAX_WIDTH + c] = mid;
      line_mem[c] = px;

      nr = 0;
      nc = 0;
      if (r >= 1) begin
        rows[nr] = r - 1;
        nr++;
      end
      if (r == h - 1) begin
        rows[nr] = r;
        nr++;
      end
      if (c >= 1) begin
        cols[nc] = c - 1;
        nc++;
      end
      if (c == w - 1) begin
        cols[nc] = c;
        nc++;
      end
      for (int a = 0; a < nr; a++) begin
        for (int b = 0; b < nc; b++) begin
          res.value     = VAL_W'(window_sum(rows[a], cols[b], r, c, w, h));
          res.row       = ROW_W'(rows[a]);
          res.col       = COL_W'(cols[b]);
          res.run_last  = (a == nr - 1) && (b == nc - 1);
          res.frame_end = (rows[a] == h - 1) && (cols[b] == w - 1);
          expected_sums.push_back(res);
        end
      end

      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) row_pos = 0;
      end
    endfunction

    function void check_sum(logic [OUT_TDATA_W-1:0] data, logic last, logic user);
      conv_result_t got, want;
      got.value     = data[VAL_W-1:0];
      got.row       = data[VAL_W +: ROW_W];
      got.col       = data[VAL_W+ROW_W +: COL_W];
      got.run_last  = last;
      got.frame_end = user;
      if (expected_sums.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: value %0d row %0d col %0d last %b end %b",
                   got.value, got.row, got.col, got.run_last, got.frame_end);
        return;
      end
      want = expected_sums.pop_front();
      if (got.value !== want.value || got.row !== want.row || got.col !== want.col ||
          got.run_last !== want.run_last || got.frame_end !== want.frame_end) begin
        errors++;
        if (errors <= 10) begin
          $display("result mismatch at %0t:", $realtime);
          $display("  expected value %0d row %0d col %0d last %b end %b",
                   want.value, want.row, want.col, want.run_last, want.frame_end);
          $display("  actual   value %0d row %0d col %0d last %b end %b",
                   got.value, got.row, got.col, got.run_last, got.frame_end);
        end
      end
    endfunction
  endclass

endpackage

// ===== tb/conv3x3_zero_border_test.sv =====
`timescale 1ns / 1ps

module conv3x3_zero_border_test;
  import c3z_pkg::*;
  import conv3x3_tb_pkg::*;

  // cycles without any transfer before the run is called hung
  localparam int STALL_LIMIT = 5000;
  // settle time after the last expected result
  localparam int DRAIN_TAIL  = 8;
  // long receiver hold-off, enough to back the pipe up into in_tready
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 60;
  // short runs into the clipped geometry limits
  localparam int EDGE_ITEMS  = 8;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  conv_checker board = new();

  // pacing knobs for the sender and the receiver, set by the stimulus; idle count for the watchdog
  bit tx_burst    = 1'b0;
  bit rx_burst    = 1'b0;
  bit rx_hold_req = 1'b0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  conv3x3_zero_border dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // watchdog: any transfer on any channel resets the count
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // one register transfer; cfg_valid stays high for a following write
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val);
  endtask

  // geometry plus all three weight rows, only while the block is idle
  task automatic load_setup(input int w, input int h, input logic [ROWC_W-1:0] top,
                            input logic [ROWC_W-1:0] mid, input logic [ROWC_W-1:0] bot);
    cfg_write(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
    cfg_write(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
    cfg_write(CFG_COEF_TOP, top);
    cfg_write(CFG_COEF_MID, mid);
    cfg_write(CFG_COEF_BOT, bot);
    cfg_valid <= 1'b0;
  endtask

  // one pixel transfer after a random gap, none in a burst; in_tvalid stays high afterwards
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    board.take_pixel(px);
  endtask

  // stop offering pixels and let every expected result come out
  task automatic wait_results();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // three q8.8 weights, biased toward the extremes
  function automatic logic [ROWC_W-1:0] pick_weights();
    logic [ROWC_W-1:0] lanes;
    for (int j = 0; j < 3; j++) begin
      case ($urandom_range(0, 6))
        0: lanes[COEF_W*j +: COEF_W] = 16'h8000;
        1: lanes[COEF_W*j +: COEF_W] = 16'h7FFF;
        2: lanes[COEF_W*j +: COEF_W] = 16'hFFFF;
        3: lanes[COEF_W*j +: COEF_W] = 16'h0000;
        4: lanes[COEF_W*j +: COEF_W] = COEF_W'($urandom_range(0, 1023)) - 16'd512;
        default: lanes[COEF_W*j +: COEF_W] = COEF_W'($urandom);
      endcase
    end
    return lanes;
  endfunction

  // result side: random stalls, bursts with ready held high, long hold-offs on request
  initial begin : result_sink
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      stall = rx_burst ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      board.check_sum(out_tdata, out_tlast, out_tuser);
    end
  end

  initial begin : stimulus
    int w, h, n, mode, fed, phase;
    logic [ROWC_W-1:0] ct, cm, cb;
    logic [PIX_W-1:0] extremes [5];
    extremes = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry and sobel weights: first row and a bit of the second
    for (int i = 0; i < 13; i++) send_pixel(extremes[i % 5]);
    wait_results();

    // width below the current column restarts the frame; -128.0 on -32768
    // everywhere gives the largest positive sum
    load_setup(3, 3, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
    repeat (9) send_pixel(16'h8000);
    wait_results();

    // zero width acts as a single column
    load_setup(0, 3, {16'hFFFF, 16'h0001, 16'h7FFF}, {16'h8000, 16'h7FFF, 16'h0000},
               {16'h0100, 16'hFF00, 16'h0080});
    send_pixel(16'h7FFF);
    send_pixel(16'h8000);
    send_pixel(16'h7FFF);
    wait_results();

    // zero height acts as a single row
    load_setup(4, 0, {16'h0100, 16'h0200, 16'h0100}, {16'h7FFF, 16'h8000, 16'hFFFF},
               {16'hFF00, 16'hFE00, 16'hFF00});
    for (int i = 0; i < 4; i++) send_pixel(extremes[(i + 1) % 5]);
    wait_results();

    // random frames, mostly small; phase 0 backs up the pipe, phase 1 pauses
    // the sender mid-frame, others may abandon a frame partway
    fed   = 0;
    phase = 0;
    while (fed < RANDOM_ITEMS) begin
      w  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
      h  = $urandom_range(1, 6);
      ct = pick_weights();
      cm = pick_weights();
      cb = pick_weights();
      mode = (phase < 2) ? phase : $urandom_range(0, 5);
      if (phase == 0) begin
        w = 6;
        h = 6;
      end
      load_setup(w, h, ct, cm, cb);
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      if (mode == 0) begin
        tx_burst    = 1'b1;
        rx_hold_req = 1'b1;
      end
      repeat ($urandom_range(1, 2)) begin
        for (int i = 0; i < w * h; i++) begin
          send_pixel(PIX_W'($urandom));
          fed++;
          if (mode == 1 && i == (w * h) / 2) wait_results();
        end
      end
      if (mode == 2) begin
        // leave a frame unfinished, then shrink the geometry below the
        // current position so counting starts over at the origin
        n = (w * h > 1) ? $urandom_range(1, w * h - 1) : 1;
        repeat (n) send_pixel(PIX_W'($urandom));
        fed = fed + n;
        wait_results();
        if (board.row_pos > 0) h = $urandom_range(1, board.row_pos);
        else if (board.col_pos > 0) w = $urandom_range(1, board.col_pos);
        load_setup(w, h, ct, cm, cb);
        repeat (w * h) send_pixel(PIX_W'($urandom));
        fed = fed + w * h;
      end
      wait_results();
      phase++;
    end

    // all-ones geometry registers: start of the widest single row, then a
    // restart into the tallest single column
    tx_burst = 1'b1;
    rx_burst = 1'b0;
    load_setup(2047, 1, pick_weights(), pick_weights(), pick_weights());
    repeat (EDGE_ITEMS) send_pixel(PIX_W'($urandom));
    wait_results();
    tx_burst = 1'b0;
    rx_burst = 1'b1;
    load_setup(1, 8191, pick_weights(), pick_weights(), pick_weights());
    repeat (EDGE_ITEMS) send_pixel(PIX_W'($urandom));
    wait_results();

    if (board.errors == 0 && board.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/c3z_pkg.sv
hw/rtl/c3z_line_buf.sv
hw/rtl/c3z_win.sv
hw/rtl/c3z_mac.sv
hw/rtl/conv3x3_zero_border.sv
hw/rtl/c3z_checker.sv
tb/conv3x3_tb_pkg.sv
tb/conv3x3_zero_border_test.sv
